// ===== design/rbfwe_pkg.sv =====
// Shared types and constants for the radial basis function warp evaluator.
package rbfwe_pkg;

	localparam logic [1:0] KERN_GAUSS   = 2'd0;
	localparam logic [1:0] KERN_SIGMOID = 2'd1;
	localparam logic [1:0] KERN_IMQ     = 2'd2;

	localparam logic [1:0] CFG_KERNEL = 2'd0;
	localparam logic [1:0] CFG_SIGMA  = 2'd1;
	localparam logic [1:0] CFG_COUNT  = 2'd2;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [15:0] SIGMA_RESET = 16'd4588;

	// table span compare width, holds any table depth up to 256
	localparam int SPAN_W = 9;
	localparam int ACC_W  = 58;

	localparam int DIV_NW    = 54;
	localparam int DIV_DW    = 32;
	localparam int DIV_QW    = 34;
	localparam int DIV_CNT_W = 6;

	localparam int SQRT_W = 55;
	localparam int ROOT_W = 28;

	// ceil(2^21 / 6): exact x/6 for x below 2^18
	localparam logic [18:0] RECIP6   = 19'd349526;
	localparam logic [31:0] EXP_ONE  = 32'h4000_0000;
	localparam logic [2:0]  SQ_LAST  = 3'd7;

	typedef enum logic [1:0] {DIV_T0, DIV_T1, DIV_SIG, DIV_INV} div_sel_t;
	typedef enum logic [1:0] {KV_ZERO, KV_GAUSS, KV_SIG, KV_IMQ} kv_sel_t;

	typedef struct packed {
		logic     load_wr;
		logic     query_ld;
		logic     start;
		logic     rd;
		logic     diff;
		logic     sqr;
		logic     sum;
		logic     div_go;
		div_sel_t div_sel;
		logic     sqrt_go;
		logic     x2;
		logic     x3;
		logic     x6;
		logic     poly;
		logic     sq;
		logic     kv_ld;
		kv_sel_t  kv_sel;
		logic     prod;
		logic     acc;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kern;
		logic       empty;
		logic       last;
		logic       big;
		logic       div_busy;
		logic       sqrt_busy;
		logic       sq_last;
		logic       out_free;
	} dp_sts_t;

endpackage

// ===== design/rbfwe_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rbfwe_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rbfwe_pkg::DIV_NW-1:0] num,
	input  logic [rbfwe_pkg::DIV_DW-1:0] den,
	output logic                        busy,
	output logic [rbfwe_pkg::DIV_QW-1:0] quo
);
	import rbfwe_pkg::*;

	localparam int DSH_W = DIV_DW + DIV_QW - 1;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NW-1:0]    rem_q;
	logic [DSH_W-1:0]     dsh_q;
	logic [DIV_QW-1:0]    quo_q;
	logic [DSH_W-1:0]     diff_w;
	logic                 ge_w;

	assign ge_w   = DSH_W'(rem_q) >= dsh_q;
	assign diff_w = DSH_W'(rem_q) - dsh_q;
	assign busy   = cnt_q != '0;
	assign quo    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_QW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, (DIV_QW-1)'(0)};
			quo_q <= '0;
		end else if (busy) begin
			if (ge_w) begin
				rem_q <= diff_w[DIV_NW-1:0];
			end
			quo_q <= {quo_q[DIV_QW-2:0], ge_w};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

// ===== design/rbfwe_sqrt.sv =====
// Bitwise integer square root (floor), one result bit per cycle.
module rbfwe_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rbfwe_pkg::SQRT_W-1:0] rad,
	output logic                         busy,
	output logic [rbfwe_pkg::ROOT_W-1:0] root
);
	import rbfwe_pkg::*;

	logic [SQRT_W-1:0] bit_q;
	logic [SQRT_W-1:0] v_q;
	logic [SQRT_W:0]   res_q;
	logic [SQRT_W:0]   trial_w;

	assign busy    = |bit_q;
	assign trial_w = res_q + (SQRT_W+1)'(bit_q);
	assign root    = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (start) begin
			bit_q <= SQRT_W'(1) << (SQRT_W - 1);
		end else begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= rad;
			res_q <= '0;
		end else if (busy) begin
			if ((SQRT_W+1)'(v_q) >= trial_w) begin
				v_q   <= v_q - trial_w[SQRT_W-1:0];
				res_q <= (res_q >> 1) + (SQRT_W+1)'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// ===== design/rbfwe_datapath.sv =====
// Datapath: config registers, center table, distance, kernel and accumulate.
module rbfwe_datapath #(
	parameter int MAX_CENTERS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rbfwe_pkg::dp_cmd_t  cmd,
	output rbfwe_pkg::dp_sts_t  sts,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [5:0]          entry_index,
	input  logic signed [15:0]  pos_x,
	input  logic signed [15:0]  pos_y,
	input  logic signed [23:0]  weight_x,
	input  logic signed [23:0]  weight_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  out_x,
	output logic signed [15:0]  out_y,
	output logic                saturated
);
	import rbfwe_pkg::*;

	localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int CNT_W = $clog2(MAX_CENTERS + 1);
	localparam int RND_W = ACC_W - 18;

	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [23:0] wx;
		logic signed [23:0] wy;
	} entry_t;

	function automatic logic [16:0] sat16(input logic signed [RND_W-1:0] v);
		logic [16:0] r;
		if (v > RND_W'(32767)) begin
			r = {1'b1, 16'h7FFF};
		end else if (v < -RND_W'(32768)) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, v[15:0]};
		end
		return r;
	endfunction

	// config
	logic [1:0]  kern_q;
	logic [15:0] sigma_q;
	logic [6:0]  count_q;

	// table
	entry_t mem [MAX_CENTERS];
	entry_t rd_q;

	logic [CNT_W-1:0] idx_q;
	logic [2:0]       sq_cnt_q;
	logic             out_valid_q;

	logic signed [15:0] qx_q, qy_q;
	logic [31:0]        s2_q;
	logic signed [16:0] dx_q, dy_q;
	logic [32:0]        dxx_q, dyy_q;
	logic [33:0]        d2_q;
	logic [21:0]        x2_q;
	logic [17:0]        x3_q;
	logic [15:0]        x6_q;
	logic [30:0]        p_q;
	logic [23:0]        kv_q;
	logic signed [48:0] px_q, py_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic signed [15:0] out_x_q, out_y_q;
	logic               sat_q;

	logic [SPAN_W-1:0]  ent_w, n_w;
	logic [15:0]        sig_w;
	logic signed [16:0] dx_w, dy_w;
	logic signed [33:0] sqx_w, sqy_w;
	logic [25:0]        x_w;
	logic [51:0]        x2p_w;
	logic [47:0]        x3p_w;
	logic [36:0]        x6p_w;
	logic [31:0]        poly_w;
	logic [61:0]        sqp_w;
	logic [31:0]        gsum_w;
	logic [DIV_QW:0]    rsum_w;
	logic [DIV_QW-1:0]  rq_w;
	logic signed [ACC_W-1:0] rx_w, ry_w;
	logic [16:0]        fx_w, fy_w;

	logic [DIV_NW-1:0]  div_num;
	logic [DIV_DW-1:0]  div_den;
	logic               div_busy;
	logic [DIV_QW-1:0]  div_quo;
	logic [SQRT_W-1:0]  sq_rad;
	logic               sqrt_busy;
	logic [ROOT_W-1:0]  root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q  <= KERN_GAUSS;
			sigma_q <= SIGMA_RESET;
			count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KERNEL: kern_q  <= cfg_data[1:0];
				CFG_SIGMA:  sigma_q <= cfg_data;
				CFG_COUNT:  count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign ent_w = SPAN_W'(entry_index);
	assign n_w   = (SPAN_W'(count_q) > SPAN_W'(MAX_CENTERS)) ? SPAN_W'(MAX_CENTERS)
	                                                          : SPAN_W'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && (ent_w < SPAN_W'(MAX_CENTERS))) begin
			mem[ent_w[IDX_W-1:0]] <= {pos_x, pos_y, weight_x, weight_y};
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q[IDX_W-1:0]];
		end
	end

	rbfwe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	rbfwe_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_go),
		.rad    (sq_rad),
		.busy   (sqrt_busy),
		.root   (root)
	);

	assign sig_w  = (sigma_q == '0) ? 16'd1 : sigma_q;
	assign dx_w   = {qx_q[15], qx_q} - {rd_q.cx[15], rd_q.cx};
	assign dy_w   = {qy_q[15], qy_q} - {rd_q.cy[15], rd_q.cy};
	assign sqx_w  = dx_q * dx_q;
	assign sqy_w  = dy_q * dy_q;
	assign x_w    = {div_quo[19:0], 6'b0};
	assign x2p_w  = x_w * x_w;
	assign x3p_w  = x2_q * x_w;
	assign x6p_w  = x3_q * RECIP6;
	assign poly_w = EXP_ONE - 32'(x_w) + 32'(x2_q[21:1]) - 32'(x6_q);
	assign sqp_w  = p_q * p_q;
	assign gsum_w = 32'(p_q) + 32'd8192;
	assign rsum_w = (DIV_QW+1)'(div_quo) + (DIV_QW+1)'(1);
	assign rq_w   = rsum_w[DIV_QW:1];
	assign sq_rad = {({1'b0, d2_q, 4'b0} + 39'(s2_q)), 16'b0};

	always_comb begin
		case (cmd.div_sel)
			DIV_T0: begin
				div_num = DIV_NW'({d2_q, 19'b0});
				div_den = s2_q;
			end
			DIV_T1: begin
				div_num = {d2_q, 20'b0};
				div_den = s2_q;
			end
			DIV_SIG: begin
				div_num = DIV_NW'({p_q, 17'b0});
				div_den = EXP_ONE + 32'(p_q);
			end
			default: begin
				div_num = DIV_NW'(1) << 41;
				div_den = DIV_DW'(root);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.acc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.poly) begin
				sq_cnt_q <= '0;
			end else if (cmd.sq) begin
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rx_w = acc_x_q + (ACC_W'(1) <<< 17);
	assign ry_w = acc_y_q + (ACC_W'(1) <<< 17);
	assign fx_w = sat16($signed(rx_w[ACC_W-1:18]));
	assign fy_w = sat16($signed(ry_w[ACC_W-1:18]));

	always_ff @(posedge clk) begin
		if (cmd.query_ld) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
		end
		if (cmd.start) begin
			s2_q    <= sig_w * sig_w;
			acc_x_q <= {{(ACC_W-34){qx_q[15]}}, qx_q, 18'b0};
			acc_y_q <= {{(ACC_W-34){qy_q[15]}}, qy_q, 18'b0};
		end
		if (cmd.diff) begin
			dx_q <= dx_w;
			dy_q <= dy_w;
		end
		if (cmd.sqr) begin
			dxx_q <= sqx_w[32:0];
			dyy_q <= sqy_w[32:0];
		end
		if (cmd.sum) begin
			d2_q <= 34'(dxx_q) + 34'(dyy_q);
		end
		if (cmd.x2) begin
			x2_q <= x2p_w[51:30];
		end
		if (cmd.x3) begin
			x3_q <= x3p_w[47:30];
		end
		if (cmd.x6) begin
			x6_q <= x6p_w[36:21];
		end
		if (cmd.poly) begin
			p_q <= poly_w[30:0];
		end else if (cmd.sq) begin
			p_q <= sqp_w[60:30];
		end
		if (cmd.kv_ld) begin
			case (cmd.kv_sel)
				KV_GAUSS: kv_q <= 24'(gsum_w[31:14]);
				KV_SIG:   kv_q <= rq_w[23:0];
				KV_IMQ:   kv_q <= (|rq_w[DIV_QW-1:24]) ? 24'hFFFFFF : rq_w[23:0];
				default:  kv_q <= '0;
			endcase
		end
		if (cmd.prod) begin
			px_q <= $signed({1'b0, kv_q}) * rd_q.wx;
			py_q <= $signed({1'b0, kv_q}) * rd_q.wy;
		end
		if (cmd.acc) begin
			acc_x_q <= acc_x_q + ACC_W'(px_q);
			acc_y_q <= acc_y_q + ACC_W'(py_q);
		end
		if (cmd.emit) begin
			out_x_q <= fx_w[15:0];
			out_y_q <= fy_w[15:0];
			sat_q   <= fx_w[16] | fy_w[16];
		end
	end

	assign sts.kern      = kern_q;
	assign sts.empty     = n_w == '0;
	assign sts.last      = (SPAN_W'(idx_q) + SPAN_W'(1)) == n_w;
	assign sts.big       = (kern_q == KERN_GAUSS) ? (d2_q >= {1'b0, s2_q, 1'b0})
	                                              : (d2_q >= {2'b0, s2_q});
	assign sts.div_busy  = div_busy;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.sq_last   = sq_cnt_q == SQ_LAST;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign saturated = sat_q;

endmodule

// ===== design/rbfwe_ctrl.sv =====
// Controller state machine: sequences loads, the per-center walk and result hand-off.
module rbfwe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  rbfwe_pkg::dp_sts_t sts,
	output rbfwe_pkg::dp_cmd_t cmd
);
	import rbfwe_pkg::*;

	typedef enum logic [19:0] {
		ST_IDLE  = 20'h00001,
		ST_START = 20'h00002,
		ST_READ  = 20'h00004,
		ST_DIFF  = 20'h00008,
		ST_SQR   = 20'h00010,
		ST_SUM   = 20'h00020,
		ST_KSEL  = 20'h00040,
		ST_TDIV  = 20'h00080,
		ST_X2    = 20'h00100,
		ST_X3    = 20'h00200,
		ST_X6    = 20'h00400,
		ST_POLY  = 20'h00800,
		ST_SQ    = 20'h01000,
		ST_EXPD  = 20'h02000,
		ST_RDIV  = 20'h04000,
		ST_ROOT  = 20'h08000,
		ST_IDIV  = 20'h10000,
		ST_PROD  = 20'h20000,
		ST_ACC   = 20'h40000,
		ST_FIN   = 20'h80000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (action == ACT_QUERY) begin
						cmd.query_ld = 1'b1;
						state_d      = ST_START;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = sts.empty ? ST_FIN : ST_READ;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SQR;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_KSEL;
			end
			ST_KSEL: begin
				case (sts.kern) inside
					KERN_GAUSS, KERN_SIGMOID: begin
						if (sts.big) begin
							// exponent past range: kernel is zero
							cmd.kv_ld  = 1'b1;
							cmd.kv_sel = KV_ZERO;
							state_d    = ST_PROD;
						end else begin
							cmd.div_go  = 1'b1;
							cmd.div_sel = (sts.kern == KERN_GAUSS) ? DIV_T0 : DIV_T1;
							state_d     = ST_TDIV;
						end
					end
					KERN_IMQ: begin
						cmd.sqrt_go = 1'b1;
						state_d     = ST_ROOT;
					end
					default: begin
						cmd.kv_ld  = 1'b1;
						cmd.kv_sel = KV_ZERO;
						state_d    = ST_PROD;
					end
				endcase
			end
			ST_TDIV: begin
				if (!sts.div_busy) begin
					state_d = ST_X2;
				end
			end
			ST_X2: begin
				cmd.x2  = 1'b1;
				state_d = ST_X3;
			end
			ST_X3: begin
				cmd.x3  = 1'b1;
				state_d = ST_X6;
			end
			ST_X6: begin
				cmd.x6  = 1'b1;
				state_d = ST_POLY;
			end
			ST_POLY: begin
				cmd.poly = 1'b1;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq = 1'b1;
				if (sts.sq_last) begin
					state_d = ST_EXPD;
				end
			end
			ST_EXPD: begin
				if (sts.kern == KERN_GAUSS) begin
					cmd.kv_ld  = 1'b1;
					cmd.kv_sel = KV_GAUSS;
					state_d    = ST_PROD;
				end else begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = DIV_SIG;
					state_d     = ST_RDIV;
				end
			end
			ST_RDIV: begin
				if (!sts.div_busy) begin
					cmd.kv_ld  = 1'b1;
					cmd.kv_sel = KV_SIG;
					state_d    = ST_PROD;
				end
			end
			ST_ROOT: begin
				if (!sts.sqrt_busy) begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = DIV_INV;
					state_d     = ST_IDIV;
				end
			end
			ST_IDIV: begin
				if (!sts.div_busy) begin
					cmd.kv_ld  = 1'b1;
					cmd.kv_sel = KV_IMQ;
					state_d    = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? ST_FIN : ST_READ;
			end
			ST_FIN: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== design/rbf_warp_evaluator.sv =====
// Top level of the radial basis function warp evaluator.
// A load beat writes one center and its weight pair and yields no result.
// A query walks the loaded centers one after another, with the Gaussian
// kernel, the reflected sigmoid or the inverse multiquadric; the kernel value
// is zero for an unused kernel code or an exponent past 16. The per-center
// work uses the shared 34-step serial divider, the 28-step square root unit
// and the eight serial squarings of the exponential. The result sits in an
// output register; a new beat is taken while it waits.
module rbf_warp_evaluator #(
	parameter int MAX_CENTERS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [5:0]         entry_index,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [23:0] weight_x,
	input  logic signed [23:0] weight_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic               saturated
);
	import rbfwe_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rbfwe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbfwe_datapath #(
		.MAX_CENTERS (MAX_CENTERS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.entry_index (entry_index),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.weight_x    (weight_x),
		.weight_y    (weight_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.saturated   (saturated)
	);

endmodule
